FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/slm_pkg.sv
// shared types and constants of the sorted list merge block
// no dependencies
package slm_pkg;

    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;

    localparam logic [ACT_W-1:0] ACT_APPEND_FIRST  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND_SECOND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MERGE         = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_MERGE
    } state_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] merged_value;
        logic                     last;
        logic                     empty_res;
        logic                     overflowed;
    } result_t;

endpackage

FILE: hdl/slm_channels.sv
// valid/ready channel interfaces for the input and result words
// depends on slm_pkg
interface slm_in_if import slm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface slm_out_if import slm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] merged_value;
    logic                     last;
    logic                     empty_res;
    logic                     overflowed;

    modport source (output valid, output merged_value, output last, output empty_res,
                    output overflowed, input ready);
    modport sink (input valid, input merged_value, input last, input empty_res,
                  input overflowed, output ready);
endinterface

FILE: hdl/slm_store.sv
// one list store: single write port, single read port, registered read data
// depends on slm_pkg
module slm_store import slm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]            rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/slm_ctrl.sv
// list counts, merge heads and sequencer; drives both stores
// depends on slm_pkg
module slm_ctrl import slm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ACT_W-1:0]         action,
    output logic                     wr_a_en,
    output logic                     wr_b_en,
    output logic [AW-1:0]            wr_a_addr,
    output logic [AW-1:0]            wr_b_addr,
    output logic [AW-1:0]            rd_a_addr,
    output logic [AW-1:0]            rd_b_addr,
    input  logic signed [DATA_W-1:0] rd_a_data,
    input  logic signed [DATA_W-1:0] rd_b_data,
    input  logic                     can_push,
    output logic                     push,
    output result_t                  res
);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic          lists_empty;
    logic          take_a;
    logic          last_pick;
    logic          done;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign lists_empty = (cnt_a_reg == '0) && (cnt_b_reg == '0);
    assign wr_a_addr   = cnt_a_reg[AW-1:0];
    assign wr_b_addr   = cnt_b_reg[AW-1:0];

    // pick first list on strict less, second list wins ties
    assign take_a = (idx_a_reg < cnt_a_reg)
                    && ((idx_b_reg >= cnt_b_reg) || (rd_a_data < rd_b_data));
    assign last_pick = take_a
        ? ((idx_a_reg + CW'(1) == cnt_a_reg) && (idx_b_reg == cnt_b_reg))
        : ((idx_a_reg == cnt_a_reg) && (idx_b_reg + CW'(1) == cnt_b_reg));
    assign done = (state_reg == ST_MERGE) && can_push && (lists_empty || last_pick);

    // read the head that will be current next cycle
    assign rd_a_addr = (idx_a_next == CW'(DEPTH)) ? '0 : idx_a_next[AW-1:0];
    assign rd_b_addr = (idx_b_next == CW'(DEPTH)) ? '0 : idx_b_next[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_MERGE))
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_a_next       = cnt_a_reg;
        cnt_b_next       = cnt_b_reg;
        idx_a_next       = idx_a_reg;
        idx_b_next       = idx_b_reg;
        ovf_next         = ovf_reg;
        wr_a_en          = 1'b0;
        wr_b_en          = 1'b0;
        push             = 1'b0;
        res.merged_value = take_a ? rd_a_data : rd_b_data;
        res.last         = last_pick;
        res.empty_res    = 1'b0;
        res.overflowed   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_a_next = '0;
                idx_b_next = '0;
                if (accept)
                begin
                    priority if (action == ACT_APPEND_FIRST)
                    begin
                        if (cnt_a_reg < CW'(DEPTH))
                        begin
                            wr_a_en    = 1'b1;
                            cnt_a_next = cnt_a_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (action == ACT_APPEND_SECOND)
                    begin
                        if (cnt_b_reg < CW'(DEPTH))
                        begin
                            wr_b_en    = 1'b1;
                            cnt_b_next = cnt_b_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = ovf_reg;
                    end
                end
            end
            ST_MERGE:
            begin
                if (can_push)
                begin
                    push = 1'b1;
                    if (lists_empty)
                    begin
                        res.merged_value = '0;
                        res.last         = 1'b1;
                        res.empty_res    = 1'b1;
                    end
                    else if (take_a)
                    begin
                        idx_a_next = idx_a_reg + CW'(1);
                    end
                    else
                    begin
                        idx_b_next = idx_b_reg + CW'(1);
                    end
                end
                if (done)
                begin
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    idx_a_next = '0;
                    idx_b_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                idx_a_next = '0;
                idx_b_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

FILE: hdl/slm_out_stage.sv
// result output register; takes a new word whenever empty or being drained
// depends on slm_pkg
module slm_out_stage import slm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t res,
    output logic    can_push,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_push   = !valid_reg || out_ready;
    assign valid_next = push || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: hdl/sorted_list_merge_top.sv
// sorted list merge: top level tying sequencer, two list stores and output register
// depends on slm_pkg, slm_channels, slm_store, slm_ctrl, slm_out_stage
//
// usage:
//   in_ch carries one word per item: action (append to first list, append to
//   second list, merge) and a signed 32-bit value. appends give no result; an
//   append to a full list is dropped and sets a sticky overflow flag. action 3 is
//   accepted and ignored.
//   a merge walks both stores and sends every stored value on out_ch, in
//   ascending order if both lists are sorted, second list first on ties, the
//   final word marked last. with both lists empty it sends one word with
//   empty_res and last set. every merge word carries the overflow flag;
//   afterwards both lists and the flag are cleared.
//   the first merge word is formed in the merge state that follows the accept
//   and is registered in the output register before out_ch sees it.
//   throughput: one append per cycle while no merge is running; a merge holds
//   the input until its last word (the empty word for an empty merge) is pushed.
//   a stall on out_ch holds the current word and freezes the merge; appends are
//   still taken while the last merge word waits.
//   reset empties both lists and clears the flag; store contents are not cleared.
module sorted_list_merge_top import slm_pkg::*;
#(
    parameter int LIST_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    slm_in_if.sink     in_ch,
    slm_out_if.source  out_ch
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);

    logic                     wr_a_en;
    logic                     wr_b_en;
    logic [AW-1:0]            wr_a_addr;
    logic [AW-1:0]            wr_b_addr;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;
    logic signed [DATA_W-1:0] rd_a_data;
    logic signed [DATA_W-1:0] rd_b_data;
    logic                     can_push;
    logic                     push;
    result_t                  res;
    result_t                  out_res;

    slm_ctrl #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .action    (in_ch.action),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_a_addr (wr_a_addr),
        .wr_b_addr (wr_b_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .can_push  (can_push),
        .push      (push),
        .res       (res)
    );

    slm_store #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_a_addr),
        .wr_data (in_ch.value),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    slm_store #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_b_addr),
        .wr_data (in_ch.value),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    slm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res),
        .can_push  (can_push),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.merged_value = out_res.merged_value;
    assign out_ch.last         = out_res.last;
    assign out_ch.empty_res    = out_res.empty_res;
    assign out_ch.overflowed   = out_res.overflowed;

endmodule

FILE: hdl/slm_checker.sv
// port-level checks of the sorted list merge block, bound to the top level
// depends on slm_pkg and assert_macros.svh
`include "assert_macros.svh"

module slm_checker import slm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic [ACT_W-1:0]         action,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] merged_value,
    input logic                     last,
    input logic                     empty_res
);

    `SLM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(merged_value) && $stable(last), "result word changed while stalled")
    `SLM_ASSERT_NOW(a_empty_shape, out_valid && empty_res, last && (merged_value == '0), "empty result not a single zero last word")
    `SLM_ASSERT_NEXT(a_merge_busy, in_valid && in_ready && (action == ACT_MERGE), !in_ready, "input still open after merge word")
    `SLM_ASSERT_NEXT(a_append_quiet, in_valid && in_ready && (action != ACT_MERGE) && !out_valid, !out_valid, "result without a merge")

endmodule

bind sorted_list_merge_top slm_checker u_slm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .action       (in_ch.action),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .merged_value (out_ch.merged_value),
    .last         (out_ch.last),
    .empty_res    (out_ch.empty_res)
);

FILE: dv/tb_sorted_list_merge_top.sv
`timescale 1ns / 100ps
// testbench for sorted_list_merge_top: appends, merges and ignored words go in through
// a queue-fed driver, a local list model predicts the merge words, a monitor checks them
// depends on slm_pkg, slm_channels and the sorted_list_merge_top rtl
module tb_sorted_list_merge_top;
    import slm_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam int ITEM_TARGET = 230;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [ACT_W-1:0]         act;
        logic signed [DATA_W-1:0] val;
        bit                       drain;
    } stim_word_t;

    logic clk;
    logic rst_n;

    slm_in_if  in_ch ();
    slm_out_if out_ch ();

    sorted_list_merge_top #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stim_word_t stim_words[$];
    result_t    merge_words_due[$];

    logic signed [DATA_W-1:0] first_list[LIST_DEPTH];
    logic signed [DATA_W-1:0] second_list[LIST_DEPTH];
    int first_len;
    int second_len;
    bit overflow_seen;

    int  error_count;
    int  counted_items;
    int  merges_taken;
    bit  offer_live;
    int  send_gap;
    int  send_calm;
    int  recv_hold;
    int  recv_calm;
    bit  long_hold_done;

    always #4 clk = ~clk;

    // list model: appends fill the lists, a merge emits the merged words
    function automatic void predict_merge_words(logic [ACT_W-1:0] act,
                                                logic signed [DATA_W-1:0] val);
        result_t word;
        int i;
        int j;
        int total;
        case (act)
            ACT_APPEND_FIRST:
                if (first_len < LIST_DEPTH)
                begin
                    first_list[first_len] = val;
                    first_len++;
                end
                else
                    overflow_seen = 1'b1;
            ACT_APPEND_SECOND:
                if (second_len < LIST_DEPTH)
                begin
                    second_list[second_len] = val;
                    second_len++;
                end
                else
                    overflow_seen = 1'b1;
            ACT_MERGE:
            begin
                total = first_len + second_len;
                word.overflowed = overflow_seen;
                if (total == 0)
                begin
                    word.merged_value = '0;
                    word.last         = 1'b1;
                    word.empty_res    = 1'b1;
                    merge_words_due.push_back(word);
                end
                else
                begin
                    i = 0;
                    j = 0;
                    for (int k = 0; k < total; k++)
                    begin
                        // second list wins ties
                        if (i < first_len && (j >= second_len || first_list[i] < second_list[j]))
                        begin
                            word.merged_value = first_list[i];
                            i++;
                        end
                        else
                        begin
                            word.merged_value = second_list[j];
                            j++;
                        end
                        word.last      = (k == total - 1);
                        word.empty_res = 1'b0;
                        merge_words_due.push_back(word);
                    end
                end
                first_len     = 0;
                second_len    = 0;
                overflow_seen = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    function automatic int draw_idle(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_value(bit narrow);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return VAL_MIN;
        if (r == 1)
            return VAL_MAX;
        if (narrow)
            return $signed(32'($urandom_range(0, 24))) - 12;
        return $signed($urandom());
    endfunction

    task automatic add_word(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                            bit drain = 1'b0);
        stim_word_t w;
        w.act   = act;
        w.val   = val;
        w.drain = drain;
        stim_words.push_back(w);
        if (act != ACT_IGNORED)
            counted_items++;
    endtask

    task automatic queue_merge_run(int n1, int n2, bit drain);
        logic signed [DATA_W-1:0] first_vals[$];
        logic signed [DATA_W-1:0] second_vals[$];
        bit narrow;
        bit pick_first;
        narrow = ($urandom_range(0, 2) == 0);
        repeat (n1) first_vals.push_back(draw_value(narrow));
        repeat (n2) second_vals.push_back(draw_value(narrow));
        // most runs are ascending, some are left out of order
        if ($urandom_range(0, 9) != 0)
        begin
            first_vals.sort();
            second_vals.sort();
        end
        while (first_vals.size() + second_vals.size() != 0)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                add_word(ACT_IGNORED, $signed($urandom()), drain);
                drain = 1'b0;
            end
            pick_first = (second_vals.size() == 0) ||
                         (first_vals.size() != 0 && $urandom_range(0, 1) == 1);
            if (pick_first)
                add_word(ACT_APPEND_FIRST, first_vals.pop_front(), drain);
            else
                add_word(ACT_APPEND_SECOND, second_vals.pop_front(), drain);
            drain = 1'b0;
        end
        add_word(ACT_MERGE, $signed($urandom()), drain);
    endtask

    // driver: accept at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predict_merge_words(in_ch.action, in_ch.value);
            if (in_ch.action == ACT_MERGE)
                merges_taken++;
            void'(stim_words.pop_front());
            offer_live = 1'b0;
        end
    end

    // driver: offer the next word at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && !offer_live)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (stim_words.size() != 0 &&
                     (!stim_words[0].drain || merge_words_due.size() == 0))
            begin
                in_ch.valid  <= 1'b1;
                in_ch.action <= stim_words[0].act;
                in_ch.value  <= stim_words[0].val;
                offer_live = 1'b1;
                send_gap = draw_idle(send_calm);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver ready, with one long hold once merges are flowing
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && merges_taken >= 8)
            begin
                recv_hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                recv_hold = draw_idle(recv_calm);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (merge_words_due.size() == 0)
            begin
                $display("%0t: unexpected merge word value %0d last %0b empty %0b ovf %0b",
                         $time, out_ch.merged_value, out_ch.last, out_ch.empty_res,
                         out_ch.overflowed);
                error_count++;
            end
            else
            begin
                want = merge_words_due.pop_front();
                if (out_ch.merged_value !== want.merged_value)
                begin
                    $display("%0t: merged_value expected %0d actual %0d",
                             $time, want.merged_value, out_ch.merged_value);
                    error_count++;
                end
                if (out_ch.last !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, out_ch.last);
                    error_count++;
                end
                if (out_ch.empty_res !== want.empty_res)
                begin
                    $display("%0t: empty_res expected %0b actual %0b",
                             $time, want.empty_res, out_ch.empty_res);
                    error_count++;
                end
                if (out_ch.overflowed !== want.overflowed)
                begin
                    $display("%0t: overflowed expected %0b actual %0b",
                             $time, want.overflowed, out_ch.overflowed);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int run_idx;
        int r;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_APPEND_FIRST;
        in_ch.value = '0;
        out_ch.ready = 1'b0;
        first_len = 0;
        second_len = 0;
        overflow_seen = 1'b0;
        error_count = 0;
        counted_items = 0;
        merges_taken = 0;
        offer_live = 1'b0;
        send_gap = 0;
        send_calm = 0;
        recv_hold = 0;
        recv_calm = 0;
        long_hold_done = 1'b0;

        // empty merge
        add_word(ACT_MERGE, VAL_MAX);
        // extremes with ties on both ends and at zero
        add_word(ACT_APPEND_FIRST, VAL_MIN);
        add_word(ACT_APPEND_SECOND, VAL_MIN);
        add_word(ACT_APPEND_FIRST, -1);
        add_word(ACT_APPEND_SECOND, 0);
        add_word(ACT_APPEND_FIRST, 0);
        add_word(ACT_APPEND_SECOND, 5);
        add_word(ACT_IGNORED, 32'h5a5a_a5a5);
        add_word(ACT_APPEND_FIRST, VAL_MAX);
        add_word(ACT_APPEND_SECOND, VAL_MAX);
        add_word(ACT_MERGE, 0);
        // lists out of order
        add_word(ACT_APPEND_FIRST, 10);
        add_word(ACT_APPEND_FIRST, 3);
        add_word(ACT_APPEND_SECOND, 7);
        add_word(ACT_MERGE, -1);
        // one list only, each side
        add_word(ACT_APPEND_FIRST, 42);
        add_word(ACT_MERGE, 0);
        add_word(ACT_APPEND_SECOND, -9);
        add_word(ACT_MERGE, 0);

        // full lists plus dropped appends
        queue_merge_run(LIST_DEPTH + 2, LIST_DEPTH + 1, 1'b0);
        run_idx = 1;
        while (counted_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                queue_merge_run($urandom_range(0, 6), $urandom_range(0, 6),
                                run_idx == 5 || $urandom_range(0, 7) == 0);
            else if (r < 92)
                queue_merge_run($urandom_range(0, 16), $urandom_range(0, 16),
                                $urandom_range(0, 7) == 0);
            else
                queue_merge_run($urandom_range(28, 36), $urandom_range(20, 36), 1'b0);
            run_idx++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_words.size() != 0 || offer_live)
            @(posedge clk);
        while (merge_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
